FILE: rtl/bwct_pkg.sv
// ----------------------------------------------------------------------------
// bwct_pkg: shared constants and types for the block work engine
// Widths of the compact target, the 256-bit value path and the result words,
// plus the data bundle that moves through the divider stages.
// ----------------------------------------------------------------------------
package bwct_pkg;

  localparam int unsigned VALUE_WIDTH   = 256;
  localparam int unsigned WORD_WIDTH    = 64;
  localparam int unsigned NUM_WORDS     = VALUE_WIDTH / WORD_WIDTH;
  localparam int unsigned IDX_WIDTH     = $clog2(NUM_WORDS);
  localparam int unsigned COMPACT_WIDTH = 32;
  localparam int unsigned EXP_WIDTH     = 8;
  localparam int unsigned MANT_WIDTH    = 23;
  // bits needed to count whole-byte shifts across the value
  localparam int unsigned SHIFT_BYTES_W = $clog2(VALUE_WIDTH / 8);
  // one restoring division step per quotient bit
  localparam int unsigned DIV_STEPS     = VALUE_WIDTH;

  // exponent of a mantissa that sits unshifted, and the first exponent
  // whose left shift pushes every mantissa bit out of the value
  localparam logic [EXP_WIDTH-1:0] EXP_BIAS  = EXP_WIDTH'(3);
  localparam logic [EXP_WIDTH-1:0] EXP_LIMIT = EXP_WIDTH'(VALUE_WIDTH / 8 + 3);

  localparam logic [IDX_WIDTH-1:0] LAST_INDEX = IDX_WIDTH'(NUM_WORDS - 1);
  localparam logic [IDX_WIDTH-1:0] IDX_ONE    = IDX_WIDTH'(1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [WORD_WIDTH-1:0]  word_t;

  // partial remainder, numerator/quotient shift register, divisor
  typedef struct packed {
    value_t rem;
    value_t nq;
    value_t dvs;
  } div_data_t;

endpackage

FILE: rtl/bwct_decode.sv
// ----------------------------------------------------------------------------
// bwct_decode: compact target expansion
// Stage one expands the compact word into the 256-bit target; stage two
// forms the divisor (target + 1) and the numerator (~target).
// ----------------------------------------------------------------------------
module bwct_decode (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic [bwct_pkg::COMPACT_WIDTH-1:0]     compact_bits_i,
  output logic                                   out_valid_o,
  output bwct_pkg::div_data_t                    out_data_o
);

  logic [bwct_pkg::EXP_WIDTH-1:0]  exp_w;
  logic [bwct_pkg::MANT_WIDTH-1:0] man_w;
  logic [bwct_pkg::EXP_WIDTH-1:0]  ex_up;
  logic [bwct_pkg::EXP_WIDTH-1:0]  ex_dn;
  logic [bwct_pkg::SHIFT_BYTES_W+2:0] lsh;
  logic [bwct_pkg::SHIFT_BYTES_W+2:0] rsh;
  bwct_pkg::value_t   wide_man;
  bwct_pkg::value_t   target_d;
  bwct_pkg::value_t   target_q;
  logic               v1_q;
  logic               v2_q;
  bwct_pkg::div_data_t data_d;
  bwct_pkg::div_data_t data_q;

  // split the compact word; sign bit is dropped
  assign exp_w    = compact_bits_i[bwct_pkg::COMPACT_WIDTH-1 -: bwct_pkg::EXP_WIDTH];
  assign man_w    = compact_bits_i[bwct_pkg::MANT_WIDTH-1:0];
  assign wide_man = bwct_pkg::value_t'(man_w);
  assign ex_up    = exp_w - bwct_pkg::EXP_BIAS;
  assign ex_dn    = bwct_pkg::EXP_BIAS - exp_w;
  assign lsh      = {ex_up[bwct_pkg::SHIFT_BYTES_W-1:0], 3'b000};
  assign rsh      = {ex_dn[bwct_pkg::SHIFT_BYTES_W-1:0], 3'b000};

  // place the mantissa by whole bytes, drop bits beyond the top
  always_comb begin
    priority if (exp_w <= bwct_pkg::EXP_BIAS) begin
      target_d = wide_man >> rsh;
    end else if (exp_w < bwct_pkg::EXP_LIMIT) begin
      target_d = wide_man << lsh;
    end else begin
      target_d = '0;
    end
  end

  // build the divider's starting operands
  always_comb begin
    data_d.rem = '0;
    data_d.nq  = ~target_q;
    data_d.dvs = target_q + bwct_pkg::value_t'(1);
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  // capture payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      target_q <= target_d;
    end
    if (v1_q) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/bwct_div_step.sv
// ----------------------------------------------------------------------------
// bwct_div_step: one registered restoring division step
// Shifts the next numerator bit into the remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the low end of nq.
// ----------------------------------------------------------------------------
module bwct_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bwct_pkg::div_data_t in_data_i,
  output logic                out_valid_o,
  output bwct_pkg::div_data_t out_data_o
);

  logic [bwct_pkg::VALUE_WIDTH:0]   shifted;
  logic [bwct_pkg::VALUE_WIDTH+1:0] diff;
  logic                             fits;
  logic                             valid_q;
  bwct_pkg::div_data_t              data_d;
  bwct_pkg::div_data_t              data_q;

  // trial subtract of the divisor from the shifted remainder
  assign shifted = {in_data_i.rem, in_data_i.nq[bwct_pkg::VALUE_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, in_data_i.dvs};
  assign fits    = ~diff[bwct_pkg::VALUE_WIDTH+1];

  // keep the difference when it fits, else restore
  always_comb begin
    data_d.dvs = in_data_i.dvs;
    data_d.nq  = {in_data_i.nq[bwct_pkg::VALUE_WIDTH-2:0], fits};
    if (fits) begin
      data_d.rem = diff[bwct_pkg::VALUE_WIDTH-1:0];
    end else begin
      data_d.rem = shifted[bwct_pkg::VALUE_WIDTH-1:0];
    end
  end

  // advance valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  // capture payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: rtl/bwct_div_pipe.sv
// ----------------------------------------------------------------------------
// bwct_div_pipe: chain of division steps
// One registered step per quotient bit; the finished quotient leaves in nq.
// ----------------------------------------------------------------------------
module bwct_div_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bwct_pkg::div_data_t in_data_i,
  output logic                out_valid_o,
  output bwct_pkg::value_t    quot_o
);

  logic                stage_valid [0:bwct_pkg::DIV_STEPS];
  bwct_pkg::div_data_t stage_data  [0:bwct_pkg::DIV_STEPS];

  assign stage_valid[0] = in_valid_i;
  assign stage_data[0]  = in_data_i;

  // one step per stage
  for (genvar k = 0; k < bwct_pkg::DIV_STEPS; k++) begin : g_step
    bwct_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stage_valid[k]),
      .in_data_i   (stage_data[k]),
      .out_valid_o (stage_valid[k+1]),
      .out_data_o  (stage_data[k+1])
    );
  end

  assign out_valid_o = stage_valid[bwct_pkg::DIV_STEPS];
  assign quot_o      = stage_data[bwct_pkg::DIV_STEPS].nq;

endmodule

FILE: rtl/bwct_emit.sv
// ----------------------------------------------------------------------------
// bwct_emit: final increment and word serializer
// Adds one to the quotient on load and sends the 256-bit work amount out as
// four 64-bit words, least significant first.
// ----------------------------------------------------------------------------
module bwct_emit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  bwct_pkg::value_t                   quot_i,
  output logic                               done_o,
  output bwct_pkg::word_t                    work_word_o,
  output logic [bwct_pkg::IDX_WIDTH-1:0]     word_index_o,
  output logic                               last_word_o
);

  bwct_pkg::value_t                 word_buf_d;
  bwct_pkg::value_t                 word_buf_q;
  logic [bwct_pkg::IDX_WIDTH-1:0]   idx_d;
  logic [bwct_pkg::IDX_WIDTH-1:0]   idx_q;
  logic                             act_d;
  logic                             act_q;
  logic                             at_last;

  assign at_last = (idx_q == bwct_pkg::LAST_INDEX);

  // load a new result, else step to the next word
  always_comb begin
    word_buf_d = word_buf_q;
    idx_d      = idx_q;
    act_d      = act_q;
    if (in_valid_i) begin
      word_buf_d = quot_i + bwct_pkg::value_t'(1);
      idx_d      = '0;
      act_d      = 1'b1;
    end else if (act_q) begin
      word_buf_d = word_buf_q >> bwct_pkg::WORD_WIDTH;
      idx_d      = idx_q + bwct_pkg::IDX_ONE;
      act_d      = ~at_last;
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      act_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      act_q <= act_d;
    end
  end

  // hold the result words
  always_ff @(posedge clk_i) begin
    word_buf_q <= word_buf_d;
  end

  assign done_o       = act_q;
  assign work_word_o  = word_buf_q[bwct_pkg::WORD_WIDTH-1:0];
  assign word_index_o = idx_q;
  assign last_word_o  = act_q & at_last;

`ifndef SYNTHESIS
  // a new result never arrives while an earlier one is still mid-send
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !(act_q && !at_last))
    else $error("result loaded before previous words were sent");

  // words of one result follow without gaps in index order
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_q && !at_last) |=> (act_q && idx_q == $past(idx_q) + bwct_pkg::IDX_ONE))
    else $error("result words out of order or interrupted");
`endif

endmodule

FILE: rtl/block_work_from_compact_target.sv
// ----------------------------------------------------------------------------
// block_work_from_compact_target: block work from a compact target
// Decodes a compact target word into a 256-bit target and returns the work
// amount 2^256 / (target + 1) as four 64-bit words.
//
//   channel   direction  handshake            payload
//   request   in         start / busy         compact_bits_i[31:0]
//   result    out        done_o (valid)       work_word_o[63:0], word_index_o[1:0],
//                                             last_word_o
//
// Busy stays high after each accepted request, spacing requests by the four
// words each result takes on the 64-bit result port; new requests enter while
// earlier ones are still in the pipeline. A request passes 2 decode stages,
// 256 division stages and the increment/serializer load. Reset clears all
// valid bits and the serializer's control state. The receiver cannot stall,
// so the pipeline never holds.
// ----------------------------------------------------------------------------
module block_work_from_compact_target (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bwct_pkg::COMPACT_WIDTH-1:0]  compact_bits_i,
  output logic                                done_o,
  output bwct_pkg::word_t                     work_word_o,
  output logic [bwct_pkg::IDX_WIDTH-1:0]      word_index_o,
  output logic                                last_word_o
);

  logic                             accept;
  logic [bwct_pkg::IDX_WIDTH-1:0]   gap_d;
  logic [bwct_pkg::IDX_WIDTH-1:0]   gap_q;
  logic                             dec_valid;
  bwct_pkg::div_data_t              dec_data;
  logic                             div_valid;
  bwct_pkg::value_t                 div_quot;

  assign busy   = (gap_q != '0);
  assign accept = start & ~busy;

  // space requests by the length of one result
  always_comb begin
    if (accept) begin
      gap_d = bwct_pkg::LAST_INDEX;
    end else if (busy) begin
      gap_d = gap_q - bwct_pkg::IDX_ONE;
    end else begin
      gap_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else begin
      gap_q <= gap_d;
    end
  end

  // expand the compact target
  bwct_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (accept),
    .compact_bits_i (compact_bits_i),
    .out_valid_o    (dec_valid),
    .out_data_o     (dec_data)
  );

  // divide bit by bit
  bwct_div_pipe u_div_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_data_i   (dec_data),
    .out_valid_o (div_valid),
    .quot_o      (div_quot)
  );

  // increment and send the words
  bwct_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (div_valid),
    .quot_i       (div_quot),
    .done_o       (done_o),
    .work_word_o  (work_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

`ifndef SYNTHESIS
  // an accepted request blocks the next one for the following cycles
  a_req_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy ##1 busy ##1 busy)
    else $error("request accepted too soon after the previous one");

  // the last word always closes a result that is being sent
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !last_word_o) |=> done_o)
    else $error("result ended without its last word");
`endif

endmodule
